FILE: sv/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

   localparam int unsigned COLUMNS_DEFAULT = 80;
   localparam int unsigned ROWS_DEFAULT    = 25;

   localparam int unsigned COLUMN_WIDTH  = 7;
   localparam int unsigned ROW_WIDTH     = 5;
   localparam int unsigned ADDRESS_WIDTH = 11;
   localparam int unsigned CHAR_WIDTH    = 8;
   localparam int unsigned COLOR_WIDTH   = 8;
   localparam int unsigned WORD_WIDTH    = 16;
   localparam int unsigned VALUE_WIDTH   = 32;
   localparam int unsigned DIGIT_COUNT   = 10;
   localparam int unsigned DIGIT_IDX_WIDTH = 4;
   localparam int unsigned SHIFT_CNT_WIDTH = 5;

   localparam logic [COLOR_WIDTH-1:0] COLOR_RESET  = 8'd31;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO    = 8'd48;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS   = 8'd45;

   localparam logic OP_PUT_CHAR  = 1'b0;
   localparam logic OP_PRINT_INT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_LEAD,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef enum logic [1:0] {
      EMIT_CHAR,
      EMIT_SIGN,
      EMIT_DIGIT
   } emit_kind_type;

   typedef struct packed {
      logic          ready;
      logic          load;
      logic          shift;
      logic          count;
      logic          emit;
      emit_kind_type emit_kind;
      logic          emit_last;
      logic          newline;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_op;
      logic req_newline;
      logic out_free;
      logic conv_last;
      logic negative;
      logic digit_one;
   } status_type;

endpackage

FILE: sv/tccw_if.sv
`timescale 1ns / 1ps

interface tccw_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic [tccw_pkg::CHAR_WIDTH-1:0]     char_code;
   logic signed [tccw_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, output op, output char_code, output value, input ready);
   modport sink   (input valid, input op, input char_code, input value, output ready);
endinterface

interface tccw_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [tccw_pkg::ADDRESS_WIDTH-1:0]   cell_address;
   logic [tccw_pkg::WORD_WIDTH-1:0]      cell_word;
   logic                                 last;

   modport source (output valid, output cell_address, output cell_word, output last, input ready);
   modport sink   (input valid, input cell_address, input cell_word, input last, output ready);
endinterface

FILE: sv/text_console_cell_writer_top.sv
// channel   direction  payload
// req_bus   in         op, char_code, value
// rsp_bus   out        cell_address, cell_word, last
// csr       in         csr_write_enable, csr_write_data (text color)
//
// character and newline items are taken back-to-back while rsp_bus drains
// an integer item is converted by the bit-serial binary to decimal shift register,
// one bit per cycle, then written one cell (sign, then digits) at a time
// synchronous active-high reset clears cursor to 0,0, color to 31, no pending item
// rsp_bus stalls hold the output register and pause the sign and digit writes

`timescale 1ns / 1ps

module text_console_cell_writer_top #(
   parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tccw_pkg::ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [tccw_pkg::COLOR_WIDTH-1:0]   csr_write_data,
   tccw_req_if.sink                           req_bus,
   tccw_rsp_if.source                         rsp_bus
);

   tccw_pkg::cmd_type    cmd;
   tccw_pkg::status_type status;

   tccw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tccw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

FILE: sv/tccw_ctrl.sv
`timescale 1ns / 1ps

module tccw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  tccw_pkg::status_type   status,
   output tccw_pkg::cmd_type      cmd
);

   tccw_pkg::state_type state_ff;
   tccw_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tccw_pkg::ST_IDLE: begin
            if (status.req_valid && status.out_free &&
                status.req_op == tccw_pkg::OP_PRINT_INT) begin
               state_in = tccw_pkg::ST_CONV;
            end
         end
         tccw_pkg::ST_CONV: begin
            if (status.conv_last) begin
               state_in = tccw_pkg::ST_LEAD;
            end
         end
         tccw_pkg::ST_LEAD: begin
            state_in = status.negative ? tccw_pkg::ST_SIGN : tccw_pkg::ST_DIGIT;
         end
         tccw_pkg::ST_SIGN: begin
            if (status.out_free) begin
               state_in = tccw_pkg::ST_DIGIT;
            end
         end
         tccw_pkg::ST_DIGIT: begin
            if (status.out_free && status.digit_one) begin
               state_in = tccw_pkg::ST_IDLE;
            end
         end
         default: state_in = tccw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.emit_kind = tccw_pkg::EMIT_CHAR;
      unique case (state_ff)
         tccw_pkg::ST_IDLE: begin
            cmd.ready = status.out_free;
            if (status.req_valid && status.out_free) begin
               if (status.req_op == tccw_pkg::OP_PRINT_INT) begin
                  cmd.load = 1'b1;
               end else if (status.req_newline) begin
                  cmd.newline = 1'b1;
               end else begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = tccw_pkg::EMIT_CHAR;
                  cmd.emit_last = 1'b1;
               end
            end
         end
         tccw_pkg::ST_CONV: begin
            cmd.shift = 1'b1;
         end
         tccw_pkg::ST_LEAD: begin
            cmd.count = 1'b1;
         end
         tccw_pkg::ST_SIGN: begin
            cmd.emit      = status.out_free;
            cmd.emit_kind = tccw_pkg::EMIT_SIGN;
         end
         tccw_pkg::ST_DIGIT: begin
            cmd.emit      = status.out_free;
            cmd.emit_kind = tccw_pkg::EMIT_DIGIT;
            cmd.emit_last = status.digit_one;
         end
         default: cmd = '0;
      endcase
   end

endmodule

FILE: sv/tccw_datapath.sv
`timescale 1ns / 1ps

module tccw_datapath #(
   parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tccw_pkg::ROWS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tccw_pkg::COLOR_WIDTH-1:0]     csr_write_data,
   tccw_req_if.sink                             req,
   tccw_rsp_if.source                           rsp,
   input  tccw_pkg::cmd_type                    cmd,
   output tccw_pkg::status_type                 status
);

   localparam int unsigned CW = tccw_pkg::COLUMN_WIDTH;
   localparam int unsigned RW = tccw_pkg::ROW_WIDTH;
   localparam int unsigned AW = tccw_pkg::ADDRESS_WIDTH;
   localparam int unsigned PW = CW + RW;
   localparam int unsigned VW = tccw_pkg::VALUE_WIDTH;
   localparam int unsigned DN = tccw_pkg::DIGIT_COUNT;
   localparam int unsigned DI = tccw_pkg::DIGIT_IDX_WIDTH;
   localparam int unsigned SW = tccw_pkg::SHIFT_CNT_WIDTH;

   logic [tccw_pkg::COLOR_WIDTH-1:0] color_ff, color_in;
   logic [CW-1:0]                    column_ff, column_in;
   logic [RW-1:0]                    row_ff, row_in;
   logic [VW-1:0]                    bin_ff, bin_in;
   logic [DN-1:0][3:0]               bcd_ff, bcd_in;
   logic                             neg_ff, neg_in;
   logic [SW-1:0]                    shift_cnt_ff, shift_cnt_in;
   logic [DI-1:0]                    digits_ff, digits_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                    rsp_address_ff, rsp_address_in;
   logic [tccw_pkg::WORD_WIDTH-1:0]  rsp_word_ff, rsp_word_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [DN-1:0][3:0]               bcd_adj;
   logic [DI-1:0]                    lead_count;
   logic [DI-1:0]                    digit_idx;
   logic [3:0]                       digit_val;
   logic [tccw_pkg::CHAR_WIDTH-1:0]  emit_char;
   logic [PW-1:0]                    cell_pos;
   logic [CW:0]                      column_next;
   logic [RW:0]                      row_next;

   assign req.ready        = cmd.ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.cell_address = rsp_address_ff;
   assign rsp.cell_word    = rsp_word_ff;
   assign rsp.last         = rsp_last_ff;

   assign status.req_valid   = req.valid;
   assign status.req_op      = req.op;
   assign status.req_newline = (req.char_code == tccw_pkg::CHAR_NEWLINE);
   assign status.out_free    = !rsp_valid_ff || rsp.ready;
   assign status.conv_last   = (shift_cnt_ff == '1);
   assign status.negative    = neg_ff;
   assign status.digit_one   = (digits_ff == DI'(1));

   // double dabble correction per digit
   always_comb begin
      for (int i = 0; i < DN; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      lead_count = DI'(1);
      for (int i = 0; i < DN; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            lead_count = DI'(i + 1);
         end
      end
   end

   assign digit_idx = digits_ff - DI'(1);
   assign digit_val = bcd_ff[digit_idx];

   always_comb begin
      case (cmd.emit_kind)
         tccw_pkg::EMIT_SIGN:  emit_char = tccw_pkg::CHAR_MINUS;
         tccw_pkg::EMIT_DIGIT: emit_char = tccw_pkg::CHAR_ZERO + {4'd0, digit_val};
         default:              emit_char = req.char_code;
      endcase
   end

   assign cell_pos    = PW'(row_ff) * PW'(COLUMNS) + PW'(column_ff);
   assign column_next = {1'b0, column_ff} + (CW+1)'(1);
   assign row_next    = {1'b0, row_ff} + (RW+1)'(1);

   always_comb begin
      color_in     = color_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      shift_cnt_in = shift_cnt_ff;
      digits_in    = digits_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_address_in = rsp_address_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_write_enable) begin
         color_in = csr_write_data;
      end

      if (cmd.load) begin
         neg_in       = req.value[VW-1];
         bin_in       = req.value[VW-1] ? VW'(-req.value) : VW'(req.value);
         bcd_in       = '0;
         shift_cnt_in = '0;
      end

      if (cmd.shift) begin
         bcd_in       = {bcd_adj[DN-1][2:0], bcd_adj[DN-2:0], bin_ff[VW-1]};
         bin_in       = {bin_ff[VW-2:0], 1'b0};
         shift_cnt_in = shift_cnt_ff + SW'(1);
      end

      if (cmd.count) begin
         digits_in = lead_count;
      end

      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_address_in = cell_pos[AW-1:0];
         rsp_word_in    = {color_ff, emit_char};
         rsp_last_in    = cmd.emit_last;
         if (cmd.emit_kind == tccw_pkg::EMIT_DIGIT) begin
            digits_in = digits_ff - DI'(1);
         end
      end

      if (cmd.newline || (cmd.emit && column_next == (CW+1)'(COLUMNS))) begin
         column_in = '0;
         row_in    = (row_next == (RW+1)'(ROWS)) ? '0 : row_next[RW-1:0];
      end else if (cmd.emit) begin
         column_in = column_next[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= tccw_pkg::COLOR_RESET;
         column_ff    <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         color_ff     <= color_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff         <= bin_in;
      bcd_ff         <= bcd_in;
      neg_ff         <= neg_in;
      shift_cnt_ff   <= shift_cnt_in;
      digits_ff      <= digits_in;
      rsp_address_ff <= rsp_address_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned COLUMNS       = tccw_pkg::COLUMNS_DEFAULT;
   localparam int unsigned ROWS          = tccw_pkg::ROWS_DEFAULT;
   localparam int unsigned CHAR_W        = tccw_pkg::CHAR_WIDTH;
   localparam int unsigned VALUE_W       = tccw_pkg::VALUE_WIDTH;
   localparam int unsigned COL_W         = tccw_pkg::COLUMN_WIDTH;
   localparam int unsigned ROW_W         = tccw_pkg::ROW_WIDTH;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 60;
   localparam int          LONG_HOLD     = 300;

   typedef struct packed {
      logic                             op;
      logic [tccw_pkg::CHAR_WIDTH-1:0]  char_code;
      logic [tccw_pkg::VALUE_WIDTH-1:0] value;
   } console_item_type;

   typedef struct packed {
      logic [tccw_pkg::ADDRESS_WIDTH-1:0] cell_address;
      logic [tccw_pkg::WORD_WIDTH-1:0]    cell_word;
      logic                               last;
   } cell_write_type;

   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             csr_write_enable = 1'b0;
   logic [tccw_pkg::COLOR_WIDTH-1:0] csr_write_data   = '0;

   tccw_req_if req_if ();
   tccw_rsp_if rsp_if ();

   text_console_cell_writer_top #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if)
   );

   console_item_type items_to_send[$];
   cell_write_type   cells_expected[$];

   logic [tccw_pkg::COLUMN_WIDTH-1:0] cursor_col = '0;
   logic [tccw_pkg::ROW_WIDTH-1:0]    cursor_row = '0;
   logic [tccw_pkg::COLOR_WIDTH-1:0]  text_color = tccw_pkg::COLOR_RESET;

   int cycle_count    = 0;
   int error_count    = 0;
   int items_accepted = 0;
   int ints_accepted  = 0;
   int newlines_seen  = 0;
   int cells_checked  = 0;
   int screen_wraps   = 0;
   int hold_requests  = 0;
   int holds_done     = 0;
   int src_gap        = 0;
   int sink_gap       = 0;
   int hold_left      = 0;
   bit quiet          = 1'b0;

   always #10 clock = ~clock;

   initial begin
      req_if.valid     = 1'b0;
      req_if.op        = tccw_pkg::OP_PUT_CHAR;
      req_if.char_code = '0;
      req_if.value     = '0;
      rsp_if.ready     = 1'b0;
   end

   // cursor model
   function automatic void next_row();
      cursor_col = '0;
      if (int'(cursor_row) + 1 >= ROWS) begin
         cursor_row = '0;
         screen_wraps++;
      end else begin
         cursor_row = cursor_row + ROW_W'(1);
      end
   endfunction

   function automatic void place_glyph(logic [tccw_pkg::CHAR_WIDTH-1:0] glyph, logic is_last);
      cell_write_type entry;
      int             addr;
      if (glyph == tccw_pkg::CHAR_NEWLINE) begin
         next_row();
      end else begin
         addr               = int'(cursor_row) * COLUMNS + int'(cursor_col);
         entry.cell_address = addr[tccw_pkg::ADDRESS_WIDTH-1:0];
         entry.cell_word    = {text_color, glyph};
         entry.last         = is_last;
         cells_expected.push_back(entry);
         if (int'(cursor_col) + 1 >= COLUMNS) begin
            next_row();
         end else begin
            cursor_col = cursor_col + COL_W'(1);
         end
      end
   endfunction

   function automatic void predict_cells(console_item_type item);
      logic [tccw_pkg::CHAR_WIDTH-1:0]  glyphs[$];
      logic [tccw_pkg::VALUE_WIDTH-1:0] magnitude;
      logic [tccw_pkg::VALUE_WIDTH-1:0] digit;
      if (item.op == tccw_pkg::OP_PUT_CHAR) begin
         glyphs.push_back(item.char_code);
      end else begin
         magnitude = item.value;
         if (item.value[VALUE_W-1]) begin
            magnitude = ~item.value + VALUE_W'(1);
         end
         do begin
            digit = magnitude % 10;
            glyphs.push_front(tccw_pkg::CHAR_ZERO + digit[CHAR_W-1:0]);
            magnitude = magnitude / 10;
         end while (magnitude != 0);
         if (item.value[VALUE_W-1]) begin
            glyphs.push_front(tccw_pkg::CHAR_MINUS);
         end
      end
      foreach (glyphs[i]) begin
         place_glyph(glyphs[i], i == glyphs.size() - 1);
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_cells(items_to_send[0]);
            items_accepted++;
            if (items_to_send[0].op == tccw_pkg::OP_PRINT_INT) begin
               ints_accepted++;
            end else if (items_to_send[0].char_code == tccw_pkg::CHAR_NEWLINE) begin
               newlines_seen++;
            end
            void'(items_to_send.pop_front());
            if (!quiet && $urandom_range(0, 3) == 0) begin
               src_gap = $urandom_range(1, 19);
            end
         end
         if (req_if.valid && !req_if.ready) begin
            // hold the offered item
         end else if (src_gap > 0) begin
            src_gap--;
            req_if.valid <= 1'b0;
         end else if (items_to_send.size() > 0) begin
            req_if.valid     <= 1'b1;
            req_if.op        <= items_to_send[0].op;
            req_if.char_code <= items_to_send[0].char_code;
            req_if.value     <= items_to_send[0].value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // cell monitor
   always @(posedge clock) begin
      cell_write_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (cells_expected.size() == 0) begin
               report_mismatch("unexpected cell write, address",
                               32'(rsp_if.cell_address), 0);
            end else begin
               want = cells_expected.pop_front();
               cells_checked++;
               if (rsp_if.cell_address !== want.cell_address) begin
                  report_mismatch("cell_address", 32'(rsp_if.cell_address),
                                  32'(want.cell_address));
               end
               if (rsp_if.cell_word !== want.cell_word) begin
                  report_mismatch("cell_word", 32'(rsp_if.cell_word), 32'(want.cell_word));
               end
               if (rsp_if.last !== want.last) begin
                  report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
               end
            end
         end
         if (hold_requests != holds_done) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 18);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d items and %0d cells outstanding",
                  items_to_send.size(), cells_expected.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void queue_char(logic [tccw_pkg::CHAR_WIDTH-1:0] ch);
      console_item_type item;
      item.op        = tccw_pkg::OP_PUT_CHAR;
      item.char_code = ch;
      item.value     = $urandom();
      items_to_send.push_back(item);
   endfunction

   function automatic void queue_int(logic [tccw_pkg::VALUE_WIDTH-1:0] v);
      console_item_type item;
      item.op        = tccw_pkg::OP_PRINT_INT;
      item.char_code = CHAR_W'($urandom_range(0, 255));
      item.value     = v;
      items_to_send.push_back(item);
   endfunction

   function automatic void queue_random(int count, int newline_pct, int shift_max);
      logic [tccw_pkg::VALUE_WIDTH-1:0] v;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(1, 100) <= newline_pct) begin
            queue_char(tccw_pkg::CHAR_NEWLINE);
         end else if ($urandom_range(0, 1) == 1) begin
            queue_char(CHAR_W'($urandom_range(0, 255)));
         end else begin
            v = $urandom() >> $urandom_range(0, shift_max);
            if ($urandom_range(0, 2) == 0) begin
               v = ~v + VALUE_W'(1);
            end
            queue_int(v);
         end
      end
   endfunction

   task automatic wait_until_idle();
      while (items_to_send.size() != 0 || cells_expected.size() != 0) begin
         @(posedge clock);
      end
      // a trailing newline or digit pass may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_color(logic [tccw_pkg::COLOR_WIDTH-1:0] color);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= color;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      text_color = color;
      @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_char(8'h41);
      queue_char(8'h00);
      queue_char(8'hFF);
      queue_char(8'h7F);
      queue_char(8'h80);
      queue_char(tccw_pkg::CHAR_NEWLINE);
      queue_int(0);
      queue_int(1);
      queue_int(-1);
      queue_int(9);
      queue_int(10);
      queue_int(-10);
      queue_int(32'h7FFF_FFFF);
      queue_int(32'h8000_0000);
      queue_int(1000000000);
      queue_int(999999999);
      queue_int(-123456789);
      queue_char(tccw_pkg::CHAR_NEWLINE);
      queue_char(tccw_pkg::CHAR_NEWLINE);
      queue_char(8'h20);
      wait_until_idle();

      set_color(8'h00);
      queue_random(30, 10, 31);
      wait_until_idle();

      // newline heavy, walks past the last row
      set_color(8'hFF);
      queue_random(50, 50, 31);
      wait_until_idle();

      // long numbers, no newlines, column wrap while the output is held off
      set_color(8'($urandom_range(1, 254)));
      queue_random(40, 0, 4);
      hold_requests++;
      wait_until_idle();

      set_color(8'($urandom_range(0, 255)));
      quiet = 1'b1;
      queue_random(30, 15, 31);
      wait_until_idle();

      $display("%0d items sent (%0d integers, %0d newlines), %0d cell writes checked",
               items_accepted, ints_accepted, newlines_seen, cells_checked);
      $display("five color settings, screen wrapped %0d times, one %0d-cycle output hold",
               screen_wraps, LONG_HOLD);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/tccw_pkg.sv
sv/tccw_if.sv
sv/tccw_ctrl.sv
sv/tccw_datapath.sv
sv/text_console_cell_writer_top.sv
tb/tb_top.sv
